>>> design/afp_pkg.sv
`timescale 1ns / 1ps
package afp_pkg;

  localparam int FRAME_BYTES_DEF = 30;

  localparam int VAL_W   = 16;
  localparam int WIDE_W  = 21;
  localparam int BYTE_W  = 8;
  localparam int PHASE_W = 3;
  localparam int ADDR_W  = 8;

  localparam logic [BYTE_W-1:0] CH_R     = 8'h52;
  localparam logic [BYTE_W-1:0] CH_P     = 8'h50;
  localparam logic [BYTE_W-1:0] CH_Y     = 8'h59;
  localparam logic [BYTE_W-1:0] CH_A     = 8'h41;
  localparam logic [BYTE_W-1:0] CH_S     = 8'h53;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;

  localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_ROLL  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_PITCH = 3'd2;
  localparam logic [PHASE_W-1:0] PH_YAW   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_ALT   = 3'd4;

  localparam logic [ADDR_W-1:0] REG_ANGLE_MIN = 8'd0;
  localparam logic [ADDR_W-1:0] REG_ANGLE_MAX = 8'd1;
  localparam logic [ADDR_W-1:0] REG_ALT_MIN   = 8'd2;
  localparam logic [ADDR_W-1:0] REG_ALT_MAX   = 8'd3;

  localparam logic signed [VAL_W-1:0] ANGLE_MIN_RST = -16'sd180;
  localparam logic signed [VAL_W-1:0] ANGLE_MAX_RST = 16'sd180;
  localparam logic signed [VAL_W-1:0] ALT_MIN_RST   = 16'sd0;
  localparam logic signed [VAL_W-1:0] ALT_MAX_RST   = 16'sd32767;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 16'sd32767;
  localparam logic signed [VAL_W-1:0] VAL_MIN = -16'sd32768;

  typedef struct packed {
    logic signed [VAL_W-1:0] roll;
    logic signed [VAL_W-1:0] pitch;
    logic signed [VAL_W-1:0] yaw;
    logic signed [VAL_W-1:0] altitude;
  } frame_t;

  typedef struct packed {
    logic   valid;
    frame_t frame;
  } result_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] angle_min;
    logic signed [VAL_W-1:0] angle_max;
    logic signed [VAL_W-1:0] alt_min;
    logic signed [VAL_W-1:0] alt_max;
  } bounds_t;

  function automatic logic signed [VAL_W-1:0] sat16(input logic signed [WIDE_W-1:0] v);
    logic signed [VAL_W-1:0] r;
    if (v > 21'sd32767) begin
      r = VAL_MAX;
    end else if (v < -21'sd32768) begin
      r = VAL_MIN;
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> design/afp_parse.sv
`timescale 1ns / 1ps
module afp_parse #(
  parameter int FRAME_BYTES = afp_pkg::FRAME_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  logic [afp_pkg::BYTE_W-1:0]  rx_byte,
  output afp_pkg::result_t            res
);

  localparam logic [afp_pkg::BYTE_W-1:0] FRAME_LIMIT = afp_pkg::BYTE_W'(FRAME_BYTES);

  logic [afp_pkg::PHASE_W-1:0]      phase_r, phase_nxt;
  logic                             neg_r, neg_nxt;
  logic                             started_r, started_nxt;
  logic signed [afp_pkg::VAL_W-1:0] acc_r, acc_nxt;
  logic signed [afp_pkg::VAL_W-1:0] roll_r, roll_nxt;
  logic signed [afp_pkg::VAL_W-1:0] pitch_r, pitch_nxt;
  logic signed [afp_pkg::VAL_W-1:0] yaw_r, yaw_nxt;
  logic [afp_pkg::BYTE_W-1:0]       count_r, count_nxt;

  logic [afp_pkg::BYTE_W-1:0]        end_byte;
  logic signed [afp_pkg::VAL_W-1:0]  fval;
  logic signed [afp_pkg::WIDE_W-1:0] acc_wide;
  logic signed [afp_pkg::WIDE_W-1:0] digit;
  logic signed [afp_pkg::WIDE_W-1:0] step_sum;

  always_comb begin
    unique case (phase_r)
      afp_pkg::PH_ROLL:  end_byte = afp_pkg::CH_P;
      afp_pkg::PH_PITCH: end_byte = afp_pkg::CH_Y;
      afp_pkg::PH_YAW:   end_byte = afp_pkg::CH_A;
      default:           end_byte = afp_pkg::CH_S;
    endcase
  end

  always_comb begin
    if (!neg_r) begin
      fval = acc_r;
    end else if (acc_r == afp_pkg::VAL_MIN) begin
      fval = afp_pkg::VAL_MAX;
    end else begin
      fval = -acc_r;
    end
  end

  assign acc_wide = {{(afp_pkg::WIDE_W-afp_pkg::VAL_W){acc_r[afp_pkg::VAL_W-1]}}, acc_r};
  assign digit    = $signed({{(afp_pkg::WIDE_W-afp_pkg::BYTE_W){1'b0}}, rx_byte})
                  - $signed({{(afp_pkg::WIDE_W-afp_pkg::BYTE_W){1'b0}}, afp_pkg::CH_ZERO});
  assign step_sum = (acc_wide <<< 3) + (acc_wide <<< 1) + digit;

  always_comb begin
    phase_nxt   = phase_r;
    neg_nxt     = neg_r;
    started_nxt = started_r;
    acc_nxt     = acc_r;
    roll_nxt    = roll_r;
    pitch_nxt   = pitch_r;
    yaw_nxt     = yaw_r;
    count_nxt   = count_r;
    res.valid          = 1'b0;
    res.frame.roll     = roll_r;
    res.frame.pitch    = pitch_r;
    res.frame.yaw      = yaw_r;
    res.frame.altitude = fval;
    priority if (rx_byte == afp_pkg::CH_R) begin
      phase_nxt   = afp_pkg::PH_ROLL;
      neg_nxt     = 1'b0;
      started_nxt = 1'b0;
      acc_nxt     = '0;
      count_nxt   = 8'd1;
    end else if (phase_r == afp_pkg::PH_IDLE || phase_r > afp_pkg::PH_ALT) begin
      phase_nxt = phase_r;
    end else if (count_r >= FRAME_LIMIT) begin
      phase_nxt   = afp_pkg::PH_IDLE;
      neg_nxt     = 1'b0;
      started_nxt = 1'b0;
      acc_nxt     = '0;
      count_nxt   = '0;
    end else begin
      count_nxt = count_r + 8'd1;
      if (rx_byte == end_byte) begin
        neg_nxt     = 1'b0;
        started_nxt = 1'b0;
        acc_nxt     = '0;
        phase_nxt   = phase_r + 3'd1;
        unique case (phase_r)
          afp_pkg::PH_ROLL:  roll_nxt  = fval;
          afp_pkg::PH_PITCH: pitch_nxt = fval;
          afp_pkg::PH_YAW:   yaw_nxt   = fval;
          default: begin
            res.valid = 1'b1;
            phase_nxt = afp_pkg::PH_IDLE;
            count_nxt = '0;
          end
        endcase
      end else if (!started_r && rx_byte == afp_pkg::CH_MINUS) begin
        neg_nxt     = 1'b1;
        started_nxt = 1'b1;
      end else begin
        started_nxt = 1'b1;
        acc_nxt     = afp_pkg::sat16(step_sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= afp_pkg::PH_IDLE;
      neg_r     <= 1'b0;
      started_r <= 1'b0;
      acc_r     <= '0;
      roll_r    <= '0;
      pitch_r   <= '0;
      yaw_r     <= '0;
      count_r   <= '0;
    end else if (fire) begin
      phase_r   <= phase_nxt;
      neg_r     <= neg_nxt;
      started_r <= started_nxt;
      acc_r     <= acc_nxt;
      roll_r    <= roll_nxt;
      pitch_r   <= pitch_nxt;
      yaw_r     <= yaw_nxt;
      count_r   <= count_nxt;
    end
  end

endmodule

>>> design/afp_out.sv
`timescale 1ns / 1ps
module afp_out (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             load,
  input  afp_pkg::frame_t                  frame,
  input  afp_pkg::bounds_t                 bounds,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic                             blocked,
  output logic signed [afp_pkg::VAL_W-1:0] out_roll,
  output logic signed [afp_pkg::VAL_W-1:0] out_pitch,
  output logic signed [afp_pkg::VAL_W-1:0] out_yaw,
  output logic signed [afp_pkg::VAL_W-1:0] out_altitude,
  output logic                             out_roll_bad,
  output logic                             out_pitch_bad,
  output logic                             out_yaw_bad,
  output logic                             out_altitude_bad
);

  logic            valid_r;
  afp_pkg::frame_t frame_r;
  logic [3:0]      bad_r, bad_nxt;

  always_comb begin
    bad_nxt[3] = frame.roll < bounds.angle_min || frame.roll > bounds.angle_max;
    bad_nxt[2] = frame.pitch < bounds.angle_min || frame.pitch > bounds.angle_max;
    bad_nxt[1] = frame.yaw < bounds.angle_min || frame.yaw > bounds.angle_max;
    bad_nxt[0] = frame.altitude < bounds.alt_min || frame.altitude > bounds.alt_max;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame_r <= frame;
      bad_r   <= bad_nxt;
    end
  end

  assign blocked          = valid_r && !out_ready;
  assign out_valid        = valid_r;
  assign out_roll         = frame_r.roll;
  assign out_pitch        = frame_r.pitch;
  assign out_yaw          = frame_r.yaw;
  assign out_altitude     = frame_r.altitude;
  assign out_roll_bad     = bad_r[3];
  assign out_pitch_bad    = bad_r[2];
  assign out_yaw_bad      = bad_r[1];
  assign out_altitude_bad = bad_r[0];

endmodule

>>> design/ascii_attitude_frame_parser_unit.sv
`timescale 1ns / 1ps
// Path: a byte is registered at the input, then parsed when the input register advances;
//   a closing 'S' is then registered in the result register that drives the result port.
// Throughput: one byte per cycle; the input register stalls only when a frame result meets
//   a result register that is still held by out_ready low.
// Reset (rst_n, synchronous, active low): parser idle, values zero, bounds to -180/180/0/32767.
module ascii_attitude_frame_parser_unit #(
  parameter int FRAME_BYTES = afp_pkg::FRAME_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [afp_pkg::BYTE_W-1:0]        in_rx_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [afp_pkg::VAL_W-1:0]  out_roll,
  output logic signed [afp_pkg::VAL_W-1:0]  out_pitch,
  output logic signed [afp_pkg::VAL_W-1:0]  out_yaw,
  output logic signed [afp_pkg::VAL_W-1:0]  out_altitude,
  output logic                              out_roll_bad,
  output logic                              out_pitch_bad,
  output logic                              out_yaw_bad,
  output logic                              out_altitude_bad,
  input  logic                              cfg_wr_en,
  input  logic [afp_pkg::ADDR_W-1:0]        cfg_addr,
  input  logic [afp_pkg::VAL_W-1:0]         cfg_wdata
);

  logic                       in_v_r;
  logic [afp_pkg::BYTE_W-1:0] byte_r;
  afp_pkg::bounds_t           bounds_r;
  afp_pkg::result_t           res;
  logic                       adv;
  logic                       blocked;

  assign adv      = in_v_r && !(res.valid && blocked);
  assign in_ready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_v_r <= 1'b1;
    end else if (adv) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bounds_r.angle_min <= afp_pkg::ANGLE_MIN_RST;
      bounds_r.angle_max <= afp_pkg::ANGLE_MAX_RST;
      bounds_r.alt_min   <= afp_pkg::ALT_MIN_RST;
      bounds_r.alt_max   <= afp_pkg::ALT_MAX_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        afp_pkg::REG_ANGLE_MIN: bounds_r.angle_min <= $signed(cfg_wdata);
        afp_pkg::REG_ANGLE_MAX: bounds_r.angle_max <= $signed(cfg_wdata);
        afp_pkg::REG_ALT_MIN:   bounds_r.alt_min   <= $signed(cfg_wdata);
        afp_pkg::REG_ALT_MAX:   bounds_r.alt_max   <= $signed(cfg_wdata);
        default:                bounds_r           <= bounds_r;
      endcase
    end
  end

  afp_parse #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (adv),
    .rx_byte (byte_r),
    .res     (res)
  );

  afp_out u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (adv && res.valid),
    .frame            (res.frame),
    .bounds           (bounds_r),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .blocked          (blocked),
    .out_roll         (out_roll),
    .out_pitch        (out_pitch),
    .out_yaw          (out_yaw),
    .out_altitude     (out_altitude),
    .out_roll_bad     (out_roll_bad),
    .out_pitch_bad    (out_pitch_bad),
    .out_yaw_bad      (out_yaw_bad),
    .out_altitude_bad (out_altitude_bad)
  );

  a_result_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && res.valid) |=> out_valid)
    else $error("frame result not registered");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && !adv) |-> (out_valid && !out_ready && res.valid))
    else $error("input stage stalled without a blocked result");

  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(adv && res.valid))
    else $error("result valid rose without a closing beat");

endmodule

>>> tb/ascii_attitude_frame_parser_unit_tb.sv
`timescale 1ns / 1ps
module ascii_attitude_frame_parser_unit_tb;
  import afp_pkg::*;

  localparam int MAX_FRAME   = FRAME_BYTES_DEF;
  localparam int ITEM_GOAL   = 1350;
  localparam int PHASES      = 7;
  localparam int HOLD_CYCLES = 250;
  localparam int STALL_LIMIT = 3000;

  typedef struct packed {
    logic signed [VAL_W-1:0] roll;
    logic signed [VAL_W-1:0] pitch;
    logic signed [VAL_W-1:0] yaw;
    logic signed [VAL_W-1:0] altitude;
    logic                    roll_bad;
    logic                    pitch_bad;
    logic                    yaw_bad;
    logic                    altitude_bad;
  } attitude_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic [BYTE_W-1:0]       in_rx_byte;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [VAL_W-1:0] out_roll;
  logic signed [VAL_W-1:0] out_pitch;
  logic signed [VAL_W-1:0] out_yaw;
  logic signed [VAL_W-1:0] out_altitude;
  logic                    out_roll_bad;
  logic                    out_pitch_bad;
  logic                    out_yaw_bad;
  logic                    out_altitude_bad;
  logic                    cfg_wr_en;
  logic [ADDR_W-1:0]       cfg_addr;
  logic [VAL_W-1:0]        cfg_wdata;

  attitude_t expected_attitudes[$];
  int        errors;
  int        items_sent;
  int        in_calm;
  int        out_calm;
  bit        long_hold_req;
  int        idle_cycles;

  // parser shadow
  logic [PHASE_W-1:0] parse_phase;
  bit                 minus_seen;
  bit                 field_open;
  int                 accum;
  int                 roll_held;
  int                 pitch_held;
  int                 yaw_held;
  int                 frame_count;
  int                 angle_lo;
  int                 angle_hi;
  int                 alt_lo;
  int                 alt_hi;

  ascii_attitude_frame_parser_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_roll         (out_roll),
    .out_pitch        (out_pitch),
    .out_yaw          (out_yaw),
    .out_altitude     (out_altitude),
    .out_roll_bad     (out_roll_bad),
    .out_pitch_bad    (out_pitch_bad),
    .out_yaw_bad      (out_yaw_bad),
    .out_altitude_bad (out_altitude_bad),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int clamp16(input int v);
    if (v > 32767) begin
      return 32767;
    end else if (v < -32768) begin
      return -32768;
    end
    return v;
  endfunction

  function automatic logic outside(input int v, input int lo, input int hi);
    return (v < lo) || (v > hi);
  endfunction

  task automatic field_reset();
    accum = 0;
    minus_seen = 1'b0;
    field_open = 1'b0;
  endtask

  task automatic parse_byte(input logic [BYTE_W-1:0] b, output bit touched, output bit made,
                            output attitude_t res);
    logic [BYTE_W-1:0] closer;
    int                v;
    touched = 1'b1;
    made = 1'b0;
    res = '0;
    if (b == CH_R) begin
      parse_phase = PH_ROLL;
      field_reset();
      frame_count = 1;
    end else if (parse_phase == PH_IDLE) begin
      touched = 1'b0;
    end else if (frame_count >= MAX_FRAME) begin
      parse_phase = PH_IDLE;
      field_reset();
      frame_count = 0;
    end else begin
      frame_count++;
      case (parse_phase)
        PH_ROLL:  closer = CH_P;
        PH_PITCH: closer = CH_Y;
        PH_YAW:   closer = CH_A;
        default:  closer = CH_S;
      endcase
      if (b == closer) begin
        v = minus_seen ? clamp16(-accum) : accum;
        case (parse_phase)
          PH_ROLL:  roll_held = v;
          PH_PITCH: pitch_held = v;
          PH_YAW:   yaw_held = v;
          default: begin
            res.roll         = roll_held[VAL_W-1:0];
            res.pitch        = pitch_held[VAL_W-1:0];
            res.yaw          = yaw_held[VAL_W-1:0];
            res.altitude     = v[VAL_W-1:0];
            res.roll_bad     = outside(roll_held, angle_lo, angle_hi);
            res.pitch_bad    = outside(pitch_held, angle_lo, angle_hi);
            res.yaw_bad      = outside(yaw_held, angle_lo, angle_hi);
            res.altitude_bad = outside(v, alt_lo, alt_hi);
            made = 1'b1;
          end
        endcase
        if (parse_phase == PH_ALT) begin
          parse_phase = PH_IDLE;
          frame_count = 0;
        end else begin
          parse_phase = parse_phase + 1'b1;
        end
        field_reset();
      end else if (!field_open && b == CH_MINUS) begin
        minus_seen = 1'b1;
        field_open = 1'b1;
      end else begin
        field_open = 1'b1;
        accum = clamp16(accum * 10 + int'(b) - 48);
      end
    end
  endtask

  task automatic report(input string msg);
    errors++;
    $display("%0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report($sformatf("%s got %0d, want %0d", name, got, want));
    end
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b, input bit typed, input attitude_t typed_res);
    int        gap;
    bit        touched;
    bit        made;
    attitude_t res;
    if (in_calm > 0) begin
      in_calm--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 19);
      if ($urandom_range(0, 15) == 0) begin
        in_calm = $urandom_range(10, 40);
      end
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    parse_byte(b, touched, made, res);
    if (touched) begin
      items_sent++;
    end
    if (made) begin
      expected_attitudes.push_back(typed ? typed_res : res);
    end
  endtask

  task automatic write_reg(input logic [ADDR_W-1:0] idx, input logic [VAL_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_ANGLE_MIN: angle_lo = $signed(val);
      REG_ANGLE_MAX: angle_hi = $signed(val);
      REG_ALT_MIN:   alt_lo = $signed(val);
      REG_ALT_MAX:   alt_hi = $signed(val);
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_attitudes.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_bounds(input int ph);
    case (ph)
      1: begin
        write_reg(REG_ANGLE_MIN, 16'h8000);
        write_reg(REG_ANGLE_MAX, 16'h7FFF);
        write_reg(REG_ALT_MIN, 16'h8000);
        write_reg(REG_ALT_MAX, 16'h7FFF);
      end
      2: begin
        write_reg(REG_ANGLE_MIN, 16'(100));
        write_reg(REG_ANGLE_MAX, 16'(-100));
        write_reg(REG_ALT_MIN, 16'h7FFF);
        write_reg(REG_ALT_MAX, 16'h8000);
      end
      4: begin
        write_reg(REG_ANGLE_MIN, 16'(-10));
        write_reg(REG_ANGLE_MAX, 16'(10));
        write_reg(REG_ALT_MIN, 16'(0));
        write_reg(REG_ALT_MAX, 16'(50));
      end
      6: begin
        write_reg(REG_ANGLE_MIN, 16'(0));
        write_reg(REG_ANGLE_MAX, 16'(0));
        write_reg(REG_ALT_MIN, 16'h7FFF);
        write_reg(REG_ALT_MAX, 16'h7FFF);
      end
      default: begin
        write_reg(REG_ANGLE_MIN, 16'($urandom_range(0, 800) - 400));
        write_reg(REG_ANGLE_MAX, 16'($urandom_range(0, 800) - 400));
        write_reg(REG_ALT_MIN, 16'($urandom_range(0, 800) - 400));
        write_reg(REG_ALT_MAX, 16'($urandom_range(0, 800) - 400));
        write_reg(ADDR_W'($urandom_range(4, 255)), 16'($urandom_range(0, 65535)));
      end
    endcase
    cfg_wr_en <= 1'b0;
  endtask

  task automatic play_frame();
    logic [BYTE_W-1:0] seq[$];
    logic [BYTE_W-1:0] closers[4];
    int                kind;
    int                nd;
    int                left;
    int                cut;
    closers[0] = CH_P;
    closers[1] = CH_Y;
    closers[2] = CH_A;
    closers[3] = CH_S;
    kind = $urandom_range(0, 99);
    if (kind >= 90) begin
      repeat ($urandom_range(1, 8)) seq.push_back(BYTE_W'($urandom_range(0, 255)));
    end else begin
      seq.push_back(CH_R);
      left = $urandom_range(24, 26);
      for (int f = 0; f < 4; f++) begin
        if (kind >= 60 && kind < 70) begin
          nd = (f == 3) ? left : $urandom_range(0, left);
          left -= nd;
        end else if (kind >= 70 && kind < 78) begin
          nd = $urandom_range(5, 10);
        end else begin
          if ($urandom_range(0, 3) == 0) begin
            seq.push_back(CH_MINUS);
          end
          nd = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
        end
        repeat (nd) begin
          if ($urandom_range(0, 19) == 0) begin
            seq.push_back(BYTE_W'($urandom_range(0, 255)));
          end else begin
            seq.push_back(CH_ZERO + BYTE_W'($urandom_range(0, 9)));
          end
        end
        seq.push_back(closers[f]);
      end
      // truncate
      if (kind >= 78) begin
        cut = $urandom_range(1, seq.size() - 1);
        while (seq.size() > cut) void'(seq.pop_back());
      end
    end
    foreach (seq[i]) begin
      send_byte(seq[i], 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin : result_check
    attitude_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_attitudes.size() == 0) begin
        report("result beat with nothing expected");
      end else begin
        want = expected_attitudes.pop_front();
        check_field("roll", out_roll, want.roll);
        check_field("pitch", out_pitch, want.pitch);
        check_field("yaw", out_yaw, want.yaw);
        check_field("altitude", out_altitude, want.altitude);
        check_field("roll_bad", out_roll_bad, want.roll_bad);
        check_field("pitch_bad", out_pitch_bad, want.pitch_bad);
        check_field("yaw_bad", out_yaw_bad, want.yaw_bad);
        check_field("altitude_bad", out_altitude_bad, want.altitude_bad);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : result_sink
    int gap;
    out_ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (out_calm > 0) begin
          out_calm--;
          gap = 0;
        end else begin
          gap = $urandom_range(0, 19);
          if ($urandom_range(0, 7) == 0) begin
            out_calm = $urandom_range(5, 20);
          end
        end
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    string     directed_text;
    attitude_t typed_res[2];
    int        k;
    errors        = 0;
    items_sent    = 0;
    in_calm       = 0;
    out_calm      = 0;
    long_hold_req = 1'b0;
    parse_phase   = PH_IDLE;
    field_reset();
    roll_held   = 0;
    pitch_held  = 0;
    yaw_held    = 0;
    frame_count = 0;
    angle_lo    = ANGLE_MIN_RST;
    angle_hi    = ANGLE_MAX_RST;
    alt_lo      = ALT_MIN_RST;
    alt_hi      = ALT_MAX_RST;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_rx_byte <= '0;
    cfg_wr_en  <= 1'b0;
    cfg_addr   <= '0;
    cfg_wdata  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idle byte, empty frame, restart mid-field, saturated and negated fields
    directed_text = "ZRPYASR7R40000P-40000YA-S";
    typed_res[0]  = '0;
    typed_res[1]  = '{16'sd32767, -16'sd32767, 16'sd0, 16'sd0, 1'b1, 1'b1, 1'b0, 1'b0};
    k = 0;
    for (int i = 0; i < directed_text.len(); i++) begin
      if (directed_text[i] == CH_S) begin
        send_byte(directed_text[i], 1'b1, typed_res[k]);
        k++;
      end else begin
        send_byte(directed_text[i], 1'b0, '0);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        drain();
        set_bounds(ph);
      end
      if (ph == 4) begin
        long_hold_req = 1'b1;
      end
      while (items_sent < (ITEM_GOAL * (ph + 1)) / PHASES) play_frame();
    end
    drain();
    if (expected_attitudes.size() != 0) begin
      report($sformatf("%0d results never arrived", expected_attitudes.size()));
    end
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
